// ----- rtl/core/hai_pkg.sv -----
// Hall angle interpolator package: shared types, codes and constants.
// Used by hai_ctrl, hai_datapath and hall_angle_interpolator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hai_pkg;

    localparam int ANGLE_OUT_W   = 16;
    localparam int PERIOD_FIELD_W = 16;
    localparam int STEP_W        = 15;
    localparam int SPEED_W       = 24;
    localparam int OFFSET_W      = 16;
    localparam int INC_NUM_W     = 24;
    localparam int SPD_NUM_W     = 26;
    localparam int CFG_DATA_W    = 26;
    localparam int CFG_IDX_W     = 2;
    localparam int HALL_W        = 3;

    // Both quotients run in lockstep over the widest numerator.
    localparam int DIV_STEPS     = SPD_NUM_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [OFFSET_W-1:0]  PHASE_OFFSET_RST = 16'd40050;
    localparam logic [INC_NUM_W-1:0] INC_NUM_RST      = 24'd3495253;
    localparam logic [SPD_NUM_W-1:0] SPD_NUM_RST      = 26'd32000000;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_CAPTURE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_NUM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_NUM      = 2'd2;

    typedef logic [2:0] t_sector;
    localparam t_sector NO_SECTOR = 3'd7;

    // Sector per Hall code: 5,4,6,2,3,1 -> 0..5; 0 and 7 are invalid.
    localparam t_sector SECTOR_OF_HALL [8] = '{
        NO_SECTOR, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, NO_SECTOR
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_needed;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/hai_datapath.sv -----
// Hall angle interpolator datapath: config registers, angle/step/speed state,
// twin restoring dividers and the output register. Depends on hai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hai_datapath #(
    parameter int ANGLE_BITS  = 16,
    parameter int PERIOD_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire hai_pkg::t_dp_cmd                   i_cmd,
    output hai_pkg::t_dp_sts                        o_sts,
    input  wire logic                               i_kind,
    input  wire logic [hai_pkg::PERIOD_FIELD_W-1:0] i_edge_period,
    input  wire logic [hai_pkg::HALL_W-1:0]         i_hall_state,
    input  wire logic                               i_cfg_valid,
    input  wire logic [hai_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hai_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic      [hai_pkg::ANGLE_OUT_W-1:0]    o_angle,
    output logic      [hai_pkg::STEP_W-1:0]         o_angle_step,
    output logic      [hai_pkg::SPEED_W-1:0]        o_speed_rpm,
    output logic                                    o_hall_invalid
);

    localparam int PW = (PERIOD_BITS < hai_pkg::PERIOD_FIELD_W) ?
                        PERIOD_BITS : hai_pkg::PERIOD_FIELD_W;
    localparam int NW = hai_pkg::DIV_STEPS;
    localparam int SUM_W = (ANGLE_BITS > hai_pkg::STEP_W) ? ANGLE_BITS : hai_pkg::STEP_W;
    localparam int OFS_W = (ANGLE_BITS > hai_pkg::OFFSET_W) ? ANGLE_BITS : hai_pkg::OFFSET_W;
    localparam int OUT_W = (ANGLE_BITS > hai_pkg::ANGLE_OUT_W) ?
                           ANGLE_BITS : hai_pkg::ANGLE_OUT_W;

    logic [hai_pkg::OFFSET_W-1:0]  r_phase_offset;
    logic [hai_pkg::INC_NUM_W-1:0] r_inc_num;
    logic [hai_pkg::SPD_NUM_W-1:0] r_spd_num;

    logic [ANGLE_BITS-1:0]        r_angle;
    logic [hai_pkg::STEP_W-1:0]   r_step;
    logic [hai_pkg::SPEED_W-1:0]  r_speed;

    logic                         r_kind;
    hai_pkg::t_sector             r_sector;
    logic                         r_div_used;
    logic [PW-1:0]                r_period;
    logic [NW-1:0]                r_nq_inc;
    logic [NW-1:0]                r_nq_spd;
    logic [PW-1:0]                r_rem_inc;
    logic [PW-1:0]                r_rem_spd;

    logic [hai_pkg::ANGLE_OUT_W-1:0] r_o_angle;
    logic [hai_pkg::STEP_W-1:0]      r_o_step;
    logic [hai_pkg::SPEED_W-1:0]     r_o_speed;
    logic                            r_o_invalid;

    logic [ANGLE_BITS-1:0] w_base [6];

    for (genvar k = 0; k < 6; k++) begin : g_base
        localparam logic [63:0] BASE = ((64'(k) << ANGLE_BITS) + 64'd3) / 64'd6;
        assign w_base[k] = BASE[ANGLE_BITS-1:0];
    end

    // divider trial subtract, one quotient bit per cycle
    logic [PW:0]   w_trial_inc, w_trial_spd, w_diff_inc, w_diff_spd;
    logic          w_qb_inc, w_qb_spd;
    logic [PW-1:0] n_rem_inc, n_rem_spd;

    always_comb begin
        w_trial_inc = {r_rem_inc, r_nq_inc[NW-1]};
        w_trial_spd = {r_rem_spd, r_nq_spd[NW-1]};
        w_diff_inc  = w_trial_inc - {1'b0, r_period};
        w_diff_spd  = w_trial_spd - {1'b0, r_period};
        w_qb_inc    = (w_trial_inc >= {1'b0, r_period});
        w_qb_spd    = (w_trial_spd >= {1'b0, r_period});
        n_rem_inc   = w_qb_inc ? w_diff_inc[PW-1:0] : w_trial_inc[PW-1:0];
        n_rem_spd   = w_qb_spd ? w_diff_spd[PW-1:0] : w_trial_spd[PW-1:0];
    end

    logic [hai_pkg::STEP_W-1:0]  w_step_sat;
    logic [hai_pkg::SPEED_W-1:0] w_speed_sat;
    logic [SUM_W-1:0]            w_tick_sum;
    logic [OFS_W-1:0]            w_snap_sum;
    logic                        w_invalid;
    logic [ANGLE_BITS-1:0]       n_angle;
    logic [hai_pkg::STEP_W-1:0]  n_step;
    logic [hai_pkg::SPEED_W-1:0] n_speed;
    logic [OUT_W-1:0]            w_angle_out;

    always_comb begin
        w_step_sat  = (|r_nq_inc[NW-1:hai_pkg::STEP_W]) ? hai_pkg::STEP_MAX :
                      r_nq_inc[hai_pkg::STEP_W-1:0];
        w_speed_sat = (|r_nq_spd[NW-1:hai_pkg::SPEED_W]) ? hai_pkg::SPEED_MAX :
                      r_nq_spd[hai_pkg::SPEED_W-1:0];
        w_tick_sum  = SUM_W'(r_angle) + SUM_W'(r_step);
        w_snap_sum  = OFS_W'(w_base[r_sector]) + OFS_W'(r_phase_offset);
        w_invalid   = (r_kind == hai_pkg::KIND_CAPTURE) && (r_sector == hai_pkg::NO_SECTOR);
        n_angle     = r_angle;
        n_step      = r_step;
        n_speed     = r_speed;
        if (r_kind == hai_pkg::KIND_TICK) begin
            n_angle = w_tick_sum[ANGLE_BITS-1:0];
        end else begin
            if (r_div_used) begin
                n_step  = w_step_sat;
                n_speed = w_speed_sat;
            end
            if (!w_invalid) begin
                n_angle = w_snap_sum[ANGLE_BITS-1:0];
            end
        end
        w_angle_out = OUT_W'(n_angle);
    end

    assign o_sts.div_needed = (i_kind == hai_pkg::KIND_CAPTURE) &&
                              (i_edge_period[PW-1:0] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_offset <= hai_pkg::PHASE_OFFSET_RST;
            r_inc_num      <= hai_pkg::INC_NUM_RST;
            r_spd_num      <= hai_pkg::SPD_NUM_RST;
            r_angle        <= '0;
            r_step         <= '0;
            r_speed        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hai_pkg::CFG_PHASE_OFFSET: r_phase_offset <= i_cfg_data[hai_pkg::OFFSET_W-1:0];
                    hai_pkg::CFG_INC_NUM:      r_inc_num <= i_cfg_data[hai_pkg::INC_NUM_W-1:0];
                    hai_pkg::CFG_SPD_NUM:      r_spd_num <= i_cfg_data[hai_pkg::SPD_NUM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_angle <= n_angle;
                r_step  <= n_step;
                r_speed <= n_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_sector   <= hai_pkg::SECTOR_OF_HALL[i_hall_state];
            r_div_used <= o_sts.div_needed;
            r_period   <= i_edge_period[PW-1:0];
            r_nq_inc   <= NW'(r_inc_num);
            r_nq_spd   <= NW'(r_spd_num);
            r_rem_inc  <= '0;
            r_rem_spd  <= '0;
        end else if (i_cmd.div_step) begin
            r_nq_inc  <= {r_nq_inc[NW-2:0], w_qb_inc};
            r_nq_spd  <= {r_nq_spd[NW-2:0], w_qb_spd};
            r_rem_inc <= n_rem_inc;
            r_rem_spd <= n_rem_spd;
        end
        if (i_cmd.commit) begin
            r_o_angle   <= w_angle_out[hai_pkg::ANGLE_OUT_W-1:0];
            r_o_step    <= n_step;
            r_o_speed   <= n_speed;
            r_o_invalid <= w_invalid;
        end
    end

    assign o_angle        = r_o_angle;
    assign o_angle_step   = r_o_step;
    assign o_speed_rpm    = r_o_speed;
    assign o_hall_invalid = r_o_invalid;

endmodule

`default_nettype wire

// ----- rtl/core/hai_ctrl.sv -----
// Hall angle interpolator controller: sequences load, divide and commit,
// owns the handshakes and the output valid flag. Depends on hai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hai_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output hai_pkg::t_dp_cmd      o_cmd,
    input  wire hai_pkg::t_dp_sts i_sts
);

    localparam logic [hai_pkg::DIV_CNT_W-1:0] LAST_STEP =
        hai_pkg::DIV_CNT_W'(hai_pkg::DIV_STEPS - 1);

    hai_pkg::t_state               r_state, n_state;
    logic [hai_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hai_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_stall = (r_state != hai_pkg::S_IDLE);
        case (r_state)
            hai_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.div_needed ? hai_pkg::S_DIV : hai_pkg::S_FINISH;
                end
            end
            hai_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = hai_pkg::S_FINISH;
                end
            end
            hai_pkg::S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = hai_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hai_pkg::S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && i_stall);
    end

    assign o_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !(r_out_valid && i_stall))
        else $error("result word overwritten while held");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_sts.div_needed) |=> (r_state == hai_pkg::S_DIV && r_cnt == '0))
        else $error("divide did not start after capture load");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hai_pkg::S_DIV && r_cnt != LAST_STEP) |=> r_state == hai_pkg::S_DIV)
        else $error("divide left early");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_valid)
        else $error("commit did not raise valid");

endmodule

`default_nettype wire

// ----- rtl/core/hall_angle_interpolator.sv -----
// Hall angle interpolator top level: ports, controller and datapath.
// Depends on hai_pkg, hai_ctrl and hai_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each word gives one result word. A tick goes from load to the finish state and
// commits to the output register; a capture with a nonzero edge period first runs
// the 26-step restoring divider that forms the angle increment and speed side by
// side, one quotient bit per cycle. A capture with a zero period skips the divider.
// A new word is accepted while the previous result still waits at the output.
// Config writes are always ready; write only while the block is idle.

module hall_angle_interpolator #(
    parameter int ANGLE_BITS  = 16,
    parameter int PERIOD_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_kind,
    input  wire logic [hai_pkg::PERIOD_FIELD_W-1:0] i_edge_period,
    input  wire logic [hai_pkg::HALL_W-1:0]         i_hall_state,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [hai_pkg::ANGLE_OUT_W-1:0]    o_angle,
    output logic      [hai_pkg::STEP_W-1:0]         o_angle_step,
    output logic      [hai_pkg::SPEED_W-1:0]        o_speed_rpm,
    output logic                                    o_hall_invalid,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [hai_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hai_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    hai_pkg::t_dp_cmd w_cmd;
    hai_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    hai_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    hai_datapath #(
        .ANGLE_BITS  (ANGLE_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_edge_period  (i_edge_period),
        .i_hall_state   (i_hall_state),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_angle        (o_angle),
        .o_angle_step   (o_angle_step),
        .o_speed_rpm    (o_speed_rpm),
        .o_hall_invalid (o_hall_invalid)
    );

endmodule

`default_nettype wire
